// File: rtl/ecr_pkg.sv
// ----------------------------------------------------------------------------
// ecr_pkg
// Shared types, constants and small helpers for the exponential correlation
// row generator.
// ----------------------------------------------------------------------------
package ecr_pkg;

	// Sizing of the row store and of the correlation output.
	localparam int MAX_ROWS       = 64;
	localparam int CORR_FRAC_BITS = 16;
	localparam int CORR_W         = CORR_FRAC_BITS + 1;
	localparam int CNT_W          = $clog2(MAX_ROWS + 1);
	localparam int ADDR_W         = $clog2(MAX_ROWS);
	localparam int TIME_W         = 24;
	localparam int IDX_W          = 6;
	localparam int OUT_DATA_W     = ((2 * IDX_W + CORR_W + 7) / 8) * 8;

	// Job queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Fixed-point constants.
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [CORR_W-1:0] CORR_ONE = {1'b1, {CORR_FRAC_BITS{1'b0}}};

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOTINC  = 2'd1,
		ST_TOOMANY = 2'd2
	} status_t;

	// Kinds of work handed from the front to the back.
	typedef enum logic {
		JOB_ROW = 1'b0,
		JOB_ERR = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t             kind;
		logic [CNT_W-1:0]      row;
		logic [TIME_W-1:0]     rtime;
		status_t               status;
	} job_t;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [CORR_W-1:0] corr;
		status_t           status;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [15:0]       long_term_corr;
		logic [15:0]       decay_rate;
		logic [15:0]       time_exponent;
		logic [TIME_W-1:0] eval_time;
		logic              time_dependent;
	} cfg_t;

	// floor(2^31 / n) for the Horner divisors 1..8.
	function automatic logic [31:0] recip(input logic [3:0] n);
		logic [31:0] r;
		case (n)
			4'd1:    r = 32'd2147483648;
			4'd2:    r = 32'd1073741824;
			4'd3:    r = 32'd715827882;
			4'd4:    r = 32'd536870912;
			4'd5:    r = 32'd429496729;
			4'd6:    r = 32'd357913941;
			4'd7:    r = 32'd306783378;
			4'd8:    r = 32'd268435456;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// Low bits of a row or column count as an output index.
	function automatic logic [IDX_W-1:0] idx_field(input logic [CNT_W-1:0] v);
		logic [CNT_W+IDX_W-1:0] w;
		w = {{IDX_W{1'b0}}, v};
		return w[IDX_W-1:0];
	endfunction

endpackage

// File: rtl/ecr_ram.sv
// ----------------------------------------------------------------------------
// ecr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ecr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/ecr_queue.sv
// ----------------------------------------------------------------------------
// ecr_queue
// Short job queue that decouples the input front from the compute back.
// ----------------------------------------------------------------------------
module ecr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ecr_pkg::job_t push_job,
	input  logic          pop,
	output ecr_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	ecr_pkg::job_t                  slot_q [ecr_pkg::QUEUE_DEPTH];
	logic [ecr_pkg::QPTR_W-1:0]     wr_q;
	logic [ecr_pkg::QPTR_W-1:0]     rd_q;
	logic [ecr_pkg::QPTR_W:0]       cnt_q;

	assign full  = (cnt_q == (ecr_pkg::QPTR_W + 1)'(ecr_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// File: rtl/ecr_front.sv
// ----------------------------------------------------------------------------
// ecr_front
// Accepts rate times, checks ordering and row capacity, stores valid times
// and queues one job per item that produces results.
// ----------------------------------------------------------------------------
module ecr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ecr_pkg::TIME_W-1:0]    in_time,
	input  logic                          in_final,
	input  logic                          back_busy,
	input  logic                          q_full,
	input  logic                          q_empty,
	output logic                          q_push,
	output ecr_pkg::job_t                 q_job,
	output logic                          ram_we,
	output logic [ecr_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [ecr_pkg::TIME_W-1:0]    ram_wdata
);

	logic [ecr_pkg::CNT_W-1:0]  cnt_q;
	logic [ecr_pkg::TIME_W-1:0] last_q;
	logic                       acc;
	logic                       not_inc;
	logic                       full_rows;

	// A new frame overwrites entry 0, so it waits until the back has drained.
	assign in_ready = !q_full && !((cnt_q == '0) && (back_busy || !q_empty));
	assign acc      = in_valid && in_ready;

	assign not_inc   = (cnt_q != '0) && (in_time <= last_q);
	assign full_rows = (cnt_q >= ecr_pkg::CNT_W'(ecr_pkg::MAX_ROWS));

	assign ram_waddr = cnt_q[ecr_pkg::ADDR_W-1:0];
	assign ram_wdata = in_time;

	// Classify the accepted item.
	always_comb begin
		q_push       = 1'b0;
		ram_we       = 1'b0;
		q_job.kind   = ecr_pkg::JOB_ERR;
		q_job.row    = cnt_q;
		q_job.rtime  = in_time;
		q_job.status = ecr_pkg::ST_OK;
		if (acc) begin
			if (in_final) begin
				if (not_inc) begin
					q_push       = 1'b1;
					q_job.status = ecr_pkg::ST_NOTINC;
				end
			end else if (full_rows) begin
				q_push       = 1'b1;
				q_job.status = ecr_pkg::ST_TOOMANY;
			end else if (not_inc) begin
				q_push       = 1'b1;
				q_job.status = ecr_pkg::ST_NOTINC;
			end else begin
				q_push     = 1'b1;
				ram_we     = 1'b1;
				q_job.kind = ecr_pkg::JOB_ROW;
			end
		end
	end

	// Row count and last stored time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else if (acc) begin
			if (in_final) begin
				cnt_q <= '0;
			end else if (!full_rows && !not_inc) begin
				cnt_q  <= cnt_q + 1'b1;
				last_q <= in_time;
			end
		end
	end

endmodule

// File: rtl/ecr_back.sv
// ----------------------------------------------------------------------------
// ecr_back
// Sequencer around one shared multiplier. For each row job it walks the
// stored times, evaluates the correlation of each pair and emits the row.
// ----------------------------------------------------------------------------
module ecr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ecr_pkg::cfg_t                 cfg,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  ecr_pkg::job_t                 q_head,
	output logic                          ram_re,
	output logic [ecr_pkg::ADDR_W-1:0]    ram_raddr,
	input  logic [ecr_pkg::TIME_W-1:0]    ram_rdata,
	output logic                          busy,
	output logic                          o_valid,
	input  logic                          o_ready,
	output ecr_pkg::res_t                 o_res
);

	typedef enum logic [4:0] {
		S_IDLE, S_ERR, S_DIAG, S_RD, S_TJ, S_ZERO, S_BD, S_X, S_XL, S_Y,
		S_F, S_U, S_UR, S_VR, S_QF, S_EXPR, S_CM, S_OUT,
		S_PA, S_LM, S_LN, S_LG, S_LZ, S_POWR
	} state_t;

	localparam int RND_SH = 46 - ecr_pkg::CORR_FRAC_BITS;

	state_t                        st_q;
	logic [ecr_pkg::CNT_W-1:0]     row_q;
	logic [ecr_pkg::CNT_W-1:0]     j_q;
	logic [ecr_pkg::TIME_W-1:0]    ti_q;
	ecr_pkg::status_t              stat_q;
	logic [63:0]                   prod_q;
	logic [23:0]                   d_q;
	logic [23:0]                   x_q;
	logic [24:0]                   f_q;
	logic [29:0]                   u_q;
	logic [30:0]                   r_q;
	logic [29:0]                   v_q;
	logic [3:0]                    hn_q;
	logic [4:0]                    en_q;
	logic [30:0]                   e_q;
	logic [23:0]                   a_q;
	logic [30:0]                   m_q;
	logic [4:0]                    p_q;
	logic [23:0]                   frac_q;
	logic [4:0]                    k_q;
	logic [5:0]                    zn_q;
	logic [23:0]                   pi_q;
	logic                          pw_j_q;
	logic                          e2_pow_q;
	logic                          o_valid_q;
	ecr_pkg::res_t                 o_res_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic        slot_free;
	logic        emit;
	logic [29:0] q0;
	logic [33:0] qn;
	logic [33:0] rem;
	logic [29:0] q_fix;
	logic [30:0] r_next;
	logic [32:0] y;
	logic [47:0] sum48;
	logic [ecr_pkg::CORR_W-1:0] corr_v;
	logic [4:0]  lead;
	logic [30:0] m_norm;
	logic [31:0] sq;
	logic [30:0] z;
	logic [5:0]  sh;
	logic [30:0] r_sh;
	logic [23:0] pres;

	assign slot_free = !o_valid_q || o_ready;
	assign emit      = slot_free && (st_q inside {S_ERR, S_DIAG, S_ZERO, S_OUT});
	assign busy      = (st_q != S_IDLE);
	assign q_pop     = (st_q == S_IDLE) && !q_empty;
	assign ram_re    = (st_q == S_RD) && (j_q != row_q);
	assign ram_raddr = j_q[ecr_pkg::ADDR_W-1:0];
	assign o_valid   = o_valid_q;
	assign o_res     = o_res_q;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_BD: begin
				mul_a = {16'd0, cfg.decay_rate};
				mul_b = {8'd0, d_q};
			end
			S_XL: begin
				mul_a = {8'd0, x_q};
				mul_b = ecr_pkg::LOG2E_Q31;
			end
			S_F: begin
				mul_a = {7'd0, f_q};
				mul_b = ecr_pkg::LN2_Q32;
			end
			S_UR: begin
				mul_a = {2'd0, u_q};
				mul_b = {1'b0, r_q};
			end
			S_VR: begin
				mul_a = {2'd0, prod_q[59:30]};
				mul_b = ecr_pkg::recip(hn_q);
			end
			S_CM: begin
				mul_a = {15'd0, 17'h10000 - {1'b0, cfg.long_term_corr}};
				mul_b = {1'b0, e_q};
			end
			S_LM: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			S_LG: begin
				mul_a = {3'd0, p_q, frac_q};
				mul_b = {16'd0, cfg.time_exponent};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Horner step: quotient by a small constant with one correction.
	always_comb begin
		q0     = prod_q[60:31];
		qn     = {4'd0, q0} * {30'd0, hn_q};
		rem    = {4'd0, v_q} - qn;
		q_fix  = q0 + {29'd0, (rem >= {30'd0, hn_q})};
		r_next = ecr_pkg::Q30_ONE - {1'b0, q_fix};
	end

	// Exponent split, correlation blend and rounding.
	always_comb begin
		y      = prod_q[55:23];
		sum48  = prod_q[47:0] + ({32'd0, cfg.long_term_corr} << 30)
			+ (48'd1 << (RND_SH - 1));
		corr_v = sum48[RND_SH +: ecr_pkg::CORR_W];
	end

	// Logarithm normalization, squaring step and power result.
	always_comb begin
		lead = '0;
		for (int k = 0; k < 24; k++) begin
			if (a_q[k]) begin
				lead = 5'(k);
			end
		end
		m_norm = {7'd0, a_q} << (5'd30 - lead);
		sq     = prod_q[61:30];
		z      = {2'd0, prod_q[44:16]} + 31'h2000_0000
			- {3'd0, cfg.time_exponent, 12'd0};
		sh     = (zn_q < 6'd45) ? (6'd45 - zn_q) : 6'd0;
		r_sh   = r_q >> sh;
		pres   = (|r_sh[30:24]) ? 24'hFF_FFFF : r_sh[23:0];
	end

	// Sequencer state and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			o_valid_q <= 1'b0;
			row_q     <= '0;
			j_q       <= '0;
			hn_q      <= '0;
			k_q       <= '0;
			pw_j_q    <= 1'b0;
			e2_pow_q  <= 1'b0;
		end else begin
			// An emitting state refills the output register, otherwise a taken item leaves it.
			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (o_ready) begin
				o_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (!q_empty) begin
						row_q  <= q_head.row;
						ti_q   <= q_head.rtime;
						stat_q <= q_head.status;
						j_q    <= '0;
						if (q_head.kind == ecr_pkg::JOB_ERR) begin
							st_q <= S_ERR;
						end else if (cfg.time_dependent) begin
							a_q    <= q_head.rtime - cfg.eval_time;
							pw_j_q <= 1'b0;
							st_q   <= S_PA;
						end else begin
							st_q <= S_RD;
						end
					end
				end
				S_ERR: begin
					if (slot_free) begin
						o_res_q.row    <= ecr_pkg::idx_field(row_q);
						o_res_q.col    <= '0;
						o_res_q.corr   <= '0;
						o_res_q.status <= stat_q;
						o_res_q.last   <= 1'b1;
						st_q           <= S_IDLE;
					end
				end
				S_DIAG: begin
					if (slot_free) begin
						o_res_q.row    <= ecr_pkg::idx_field(row_q);
						o_res_q.col    <= ecr_pkg::idx_field(row_q);
						o_res_q.corr   <= ecr_pkg::CORR_ONE;
						o_res_q.status <= ecr_pkg::ST_OK;
						o_res_q.last   <= 1'b1;
						st_q           <= S_IDLE;
					end
				end
				S_RD: begin
					st_q <= (j_q == row_q) ? S_DIAG : S_TJ;
				end
				S_TJ: begin
					if (cfg.time_dependent) begin
						if (cfg.eval_time >= ram_rdata) begin
							st_q <= S_ZERO;
						end else begin
							a_q    <= ram_rdata - cfg.eval_time;
							pw_j_q <= 1'b1;
							st_q   <= S_PA;
						end
					end else begin
						d_q  <= ti_q - ram_rdata;
						st_q <= S_BD;
					end
				end
				S_ZERO: begin
					if (slot_free) begin
						o_res_q.row    <= ecr_pkg::idx_field(row_q);
						o_res_q.col    <= ecr_pkg::idx_field(j_q);
						o_res_q.corr   <= '0;
						o_res_q.status <= ecr_pkg::ST_OK;
						o_res_q.last   <= 1'b0;
						j_q            <= j_q + 1'b1;
						st_q           <= S_RD;
					end
				end
				S_BD: begin
					prod_q <= mul_p;
					st_q   <= S_X;
				end
				S_X: begin
					x_q  <= prod_q[39:16] + {23'd0, prod_q[15]};
					st_q <= S_XL;
				end
				S_XL: begin
					prod_q <= mul_p;
					st_q   <= S_Y;
				end
				S_Y: begin
					if (y[32:24] >= 9'd31) begin
						e_q  <= '0;
						st_q <= S_CM;
					end else begin
						en_q     <= y[28:24];
						f_q      <= {1'b0, y[23:0]};
						e2_pow_q <= 1'b0;
						st_q     <= S_F;
					end
				end
				S_F: begin
					prod_q <= mul_p;
					st_q   <= S_U;
				end
				S_U: begin
					u_q  <= prod_q[55:26];
					r_q  <= ecr_pkg::Q30_ONE;
					hn_q <= 4'd8;
					st_q <= S_UR;
				end
				S_UR: begin
					prod_q <= mul_p;
					st_q   <= S_VR;
				end
				S_VR: begin
					v_q    <= prod_q[59:30];
					prod_q <= mul_p;
					st_q   <= S_QF;
				end
				S_QF: begin
					r_q <= r_next;
					if (hn_q == 4'd1) begin
						st_q <= e2_pow_q ? S_POWR : S_EXPR;
					end else begin
						hn_q <= hn_q - 1'b1;
						st_q <= S_UR;
					end
				end
				S_EXPR: begin
					e_q  <= r_q >> en_q;
					st_q <= S_CM;
				end
				S_CM: begin
					prod_q <= mul_p;
					st_q   <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						o_res_q.row    <= ecr_pkg::idx_field(row_q);
						o_res_q.col    <= ecr_pkg::idx_field(j_q);
						o_res_q.corr   <= corr_v;
						o_res_q.status <= ecr_pkg::ST_OK;
						o_res_q.last   <= 1'b0;
						j_q            <= j_q + 1'b1;
						st_q           <= S_RD;
					end
				end
				S_PA: begin
					if (a_q == '0) begin
						r_q  <= '0;
						zn_q <= 6'd45;
						st_q <= S_POWR;
					end else begin
						p_q    <= lead;
						m_q    <= m_norm;
						frac_q <= '0;
						k_q    <= '0;
						st_q   <= S_LM;
					end
				end
				S_LM: begin
					prod_q <= mul_p;
					st_q   <= S_LN;
				end
				S_LN: begin
					m_q    <= sq[31] ? sq[31:1] : sq[30:0];
					frac_q <= {frac_q[22:0], sq[31]};
					if (k_q == 5'd23) begin
						st_q <= S_LG;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_LM;
					end
				end
				S_LG: begin
					prod_q <= mul_p;
					st_q   <= S_LZ;
				end
				S_LZ: begin
					zn_q     <= z[29:24];
					f_q      <= 25'h100_0000 - {1'b0, z[23:0]};
					e2_pow_q <= 1'b1;
					st_q     <= S_F;
				end
				S_POWR: begin
					if (pw_j_q) begin
						d_q  <= (pi_q > pres) ? (pi_q - pres) : (pres - pi_q);
						st_q <= S_BD;
					end else begin
						pi_q <= pres;
						st_q <= S_RD;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/exponential_correlation_rows.sv
// ----------------------------------------------------------------------------
// exponential_correlation_rows
// Streams the lower triangle of an exponential forward-rate correlation
// matrix, one row per accepted rate time.
// ----------------------------------------------------------------------------
// A rate time i produces i off-diagonal entries and then the diagonal 1.0.
// Every entry runs through one shared 32x32 multiplier under a sequencer;
// in the time-dependent form one 24-step logarithm loop and two eight-step
// Horner series dominate each entry, and each row also runs a logarithm
// loop and a Horner series for the row's own power term. A queue of four
// jobs lets the input side keep accepting while a row is computed, but
// after a final time the next item waits until all queued rows are
// finished, since the new frame reuses the time store from entry 0.
module exponential_correlation_rows (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [4:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// Input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [23:0]                       s_axis_tdata,   // rate_time
	input  logic                              s_axis_tlast,   // is_final
	// Output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ecr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // row, col, corr
	output logic [1:0]                        m_axis_tuser,   // status
	output logic                              m_axis_tlast    // last_of_row
);

	typedef enum logic [2:0] {
		REG_LTC   = 3'd0,
		REG_DECAY = 3'd1,
		REG_GAMMA = 3'd2,
		REG_EVAL  = 3'd3,
		REG_TDEP  = 3'd4
	} reg_idx_t;

	ecr_pkg::cfg_t                 cfg_q;
	logic                          cfg_wr;
	logic                          q_push;
	logic                          q_pop;
	logic                          q_full;
	logic                          q_empty;
	ecr_pkg::job_t                 q_job;
	ecr_pkg::job_t                 q_head;
	logic                          ram_we;
	logic [ecr_pkg::ADDR_W-1:0]    ram_waddr;
	logic [ecr_pkg::TIME_W-1:0]    ram_wdata;
	logic                          ram_re;
	logic [ecr_pkg::ADDR_W-1:0]    ram_raddr;
	logic [ecr_pkg::TIME_W-1:0]    ram_rdata;
	logic                          back_busy;
	ecr_pkg::res_t                 res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_term_corr <= 16'd32768;
			cfg_q.decay_rate     <= 16'd6554;
			cfg_q.time_exponent  <= 16'd32768;
			cfg_q.eval_time      <= '0;
			cfg_q.time_dependent <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_LTC:   cfg_q.long_term_corr <= pwdata[15:0];
				REG_DECAY: cfg_q.decay_rate     <= pwdata[15:0];
				REG_GAMMA: cfg_q.time_exponent  <= pwdata[15:0];
				REG_EVAL:  cfg_q.eval_time      <= pwdata[23:0];
				REG_TDEP:  cfg_q.time_dependent <= pwdata[0];
				default:   ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[4:2])
			REG_LTC:   prdata = {16'd0, cfg_q.long_term_corr};
			REG_DECAY: prdata = {16'd0, cfg_q.decay_rate};
			REG_GAMMA: prdata = {16'd0, cfg_q.time_exponent};
			REG_EVAL:  prdata = {8'd0, cfg_q.eval_time};
			REG_TDEP:  prdata = {31'd0, cfg_q.time_dependent};
			default:   prdata = '0;
		endcase
	end

	ecr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_time   (s_axis_tdata),
		.in_final  (s_axis_tlast),
		.back_busy (back_busy),
		.q_full    (q_full),
		.q_empty   (q_empty),
		.q_push    (q_push),
		.q_job     (q_job),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	ecr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	ecr_ram #(
		.WIDTH (ecr_pkg::TIME_W),
		.DEPTH (ecr_pkg::MAX_ROWS)
	) u_times (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ecr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.busy      (back_busy),
		.o_valid   (m_axis_tvalid),
		.o_ready   (m_axis_tready),
		.o_res     (res)
	);

	// Output packing.
	assign m_axis_tdata = ecr_pkg::OUT_DATA_W'({res.corr, res.col, res.row});
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.last;

`ifndef SYNTH
	// The front never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("job pushed into a full queue");

	// A new frame only overwrites the time store once the back is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_waddr == '0) |-> !back_busy)
		else $error("time store entry 0 overwritten while rows are in flight");

	// Error results always close their row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ecr_pkg::ST_OK) |-> m_axis_tlast)
		else $error("error result without last_of_row");

	// A diagonal entry carries exactly 1.0.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast && m_axis_tuser == ecr_pkg::ST_OK)
		|-> (res.corr == ecr_pkg::CORR_ONE && res.row == res.col))
		else $error("diagonal entry is not 1.0");
`endif

endmodule
